### hw/rtl/mmm_pkg.sv
package mmm_pkg;

    localparam int FRAME_BITS    = 32;
    localparam int READ_SAMPLED  = 18;
    localparam int COUNT_W       = 7;
    localparam int PHY_W         = 5;
    localparam int REG_W         = 5;
    localparam int DATA_W        = 16;
    localparam int PRE_W         = 6;
    localparam int RX_W          = 18;
    localparam int ACTION_W      = 2;
    localparam int CFG_INDEX_W   = 2;

    localparam int DEFAULT_QUEUE_DEPTH = 2;

    localparam logic [PRE_W-1:0] PREAMBLE_RESET = 6'd32;

    // action codes on the input channel
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PHY_ADDR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PREAMBLE = 2'd1;

    // classified item kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic [REG_W-1:0]  reg_addr;
        logic [DATA_W-1:0] write_data;
        logic              mdio_in;
    } item_t;

    typedef struct packed {
        logic              mdio_out;
        logic              mdio_drive;
        logic              mdc_active;
        logic              frame_done;
        logic [DATA_W-1:0] read_data;
        logic              no_response;
        logic              busy_res;
        logic              rejected;
    } result_t;

    // start 01, opcode, phy, reg, then turnaround 10 and data for a write
    function automatic logic [FRAME_BITS-1:0] build_frame(
        input logic              rd,
        input logic [PHY_W-1:0]  phy,
        input logic [REG_W-1:0]  regad,
        input logic [DATA_W-1:0] data
    );
        logic [FRAME_BITS-1:0] w;
        w = {2'b01, 2'b00, phy, regad, 2'b00, 16'h0000};
        if (rd)
        begin
            w[29:28] = 2'b10;
        end
        else
        begin
            w[29:28] = 2'b01;
            w[17:16] = 2'b10;
            w[15:0]  = data;
        end
        return w;
    endfunction

endpackage

### hw/rtl/mdio_management_master_unit.sv
// Clause 22 MDIO management master, one input beat per MDC period.
//
// Input channel (in_valid/in_ready): action 0 starts a read frame, 1 a
// write frame (reg_addr, write_data), 2 is a tick of one MDC period with
// mdio_in sampled before its rising MDC edge; code 3 is a no-op.
// Every input beat yields exactly one result beat (out_valid/out_ready)
// giving the line level for that tick, drive enable, MDC pulse, frame_done,
// read_data/no_response on the last tick of a read, busy_res and rejected.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 phy address,
// index 1 preamble length (saturates at 32). Write it only while idle.
//
// Throughput: one beat per cycle while the output side is free. A front end
// classifies beats into a QUEUE_DEPTH entry queue; the frame sequencer pops
// one entry per cycle into the result register while the output side is free.
// The queue registers the beat on acceptance and the result register then
// loads it from the queue head, after which the result is offered.
// When out_ready is low the result holds, the sequencer stops and the queue
// fills; in_ready drops only once the queue is full.
// Reset: idle, phy address 0, preamble 32, queue and result empty.
module mdio_management_master_unit #(
    parameter int QUEUE_DEPTH = mmm_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mmm_pkg::ACTION_W-1:0]      action,
    input  logic [mmm_pkg::REG_W-1:0]         reg_addr,
    input  logic [mmm_pkg::DATA_W-1:0]        write_data,
    input  logic                              mdio_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              mdio_out,
    output logic                              mdio_drive,
    output logic                              mdc_active,
    output logic                              frame_done,
    output logic [mmm_pkg::DATA_W-1:0]        read_data,
    output logic                              no_response,
    output logic                              busy_res,
    output logic                              rejected,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mmm_pkg::PRE_W-1:0]         cfg_data
);
    import mmm_pkg::*;

    // queue head between front end and sequencer
    logic    head_valid;
    logic    head_ready;
    item_t   head_item;
    result_t result;

    mmm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .mdio_in    (mdio_in),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_item  (head_item)
    );

    // frame sequencer, config registers and result register
    mmm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_ready (head_ready),
        .head_item  (head_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign mdio_out    = result.mdio_out;
    assign mdio_drive  = result.mdio_drive;
    assign mdc_active  = result.mdc_active;
    assign frame_done  = result.frame_done;
    assign read_data   = result.read_data;
    assign no_response = result.no_response;
    assign busy_res    = result.busy_res;
    assign rejected    = result.rejected;

endmodule

### hw/rtl/mmm_front.sv
module mmm_front #(
    parameter int QUEUE_DEPTH = mmm_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [mmm_pkg::ACTION_W-1:0]        action,
    input  logic [mmm_pkg::REG_W-1:0]           reg_addr,
    input  logic [mmm_pkg::DATA_W-1:0]          write_data,
    input  logic                                mdio_in,
    output logic                                head_valid,
    input  logic                                head_ready,
    output mmm_pkg::item_t                      head_item
);
    import mmm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    item_t            new_item;
    logic             push, pop;

    always_comb
    begin
        case (action)
            ACT_READ:  new_item.kind = KIND_READ;
            ACT_WRITE: new_item.kind = KIND_WRITE;
            ACT_TICK:  new_item.kind = KIND_TICK;
            default:   new_item.kind = KIND_NOP;
        endcase
        new_item.reg_addr   = reg_addr;
        new_item.write_data = write_data;
        new_item.mdio_in    = mdio_in;
    end

    assign in_ready   = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = head_valid && head_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### hw/rtl/mmm_back.sv
module mmm_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              head_valid,
    output logic                              head_ready,
    input  mmm_pkg::item_t                    head_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mmm_pkg::PRE_W-1:0]         cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output mmm_pkg::result_t                  result
);
    import mmm_pkg::*;

    localparam logic [COUNT_W-1:0] FRAME_CNT   = COUNT_W'(FRAME_BITS);
    localparam logic [COUNT_W-1:0] SAMPLE_CNT  = COUNT_W'(READ_SAMPLED);
    localparam logic [PRE_W-1:0]   PRE_MAX     = PRE_W'(FRAME_BITS);

    logic [PHY_W-1:0]      phy_reg;
    logic [PRE_W-1:0]      pre_reg;
    logic                  busy_reg, busy_next;
    logic                  is_read_reg, is_read_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [FRAME_BITS-1:0] tx_reg, tx_next;
    logic [RX_W-1:0]       rx_reg, rx_next;
    logic                  out_valid_reg;
    result_t               res_reg, res_next;
    logic                  pop;
    logic [PRE_W-1:0]      pre_sat;
    logic [COUNT_W-1:0]    count_dec;
    logic [4:0]            tx_idx;

    assign cfg_ready  = 1'b1;
    assign head_ready = !out_valid_reg || out_ready;
    assign pop        = head_valid && head_ready;
    assign out_valid  = out_valid_reg;
    assign result     = res_reg;

    assign pre_sat   = (pre_reg > PRE_MAX) ? PRE_MAX : pre_reg;
    assign count_dec = count_reg - 1'b1;
    assign tx_idx    = count_dec[4:0];

    always_comb
    begin
        busy_next    = busy_reg;
        is_read_next = is_read_reg;
        count_next   = count_reg;
        tx_next      = tx_reg;
        rx_next      = rx_reg;
        res_next     = '0;
        case (head_item.kind)
            KIND_READ, KIND_WRITE:
            begin
                if (busy_reg)
                begin
                    res_next.rejected = 1'b1;
                end
                else
                begin
                    is_read_next = (head_item.kind == KIND_READ);
                    tx_next      = build_frame(head_item.kind == KIND_READ, phy_reg,
                                               head_item.reg_addr, head_item.write_data);
                    rx_next      = '0;
                    count_next   = COUNT_W'(pre_sat) + FRAME_CNT;
                    busy_next    = 1'b1;
                end
            end
            KIND_TICK:
            begin
                if (busy_reg)
                begin
                    res_next.mdc_active = 1'b1;
                    if (count_reg > FRAME_CNT)
                    begin
                        // preamble
                        res_next.mdio_drive = 1'b1;
                        res_next.mdio_out   = 1'b1;
                    end
                    else if (is_read_reg && count_reg <= SAMPLE_CNT)
                    begin
                        rx_next = {rx_reg[RX_W-2:0], head_item.mdio_in};
                    end
                    else
                    begin
                        res_next.mdio_drive = 1'b1;
                        res_next.mdio_out   = tx_reg[tx_idx];
                    end
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        busy_next           = 1'b0;
                        res_next.frame_done = 1'b1;
                        if (is_read_reg)
                        begin
                            res_next.no_response = rx_next[DATA_W];
                            res_next.read_data   = rx_next[DATA_W] ? '0 : rx_next[DATA_W-1:0];
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res_next.busy_res = busy_next;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tx_reg  <= tx_next;
            rx_reg  <= rx_next;
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phy_reg       <= '0;
            pre_reg       <= PREAMBLE_RESET;
            busy_reg      <= 1'b0;
            is_read_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PHY_ADDR: phy_reg <= cfg_data[PHY_W-1:0];
                    CFG_PREAMBLE: pre_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (pop)
            begin
                busy_reg    <= busy_next;
                is_read_reg <= is_read_next;
                count_reg   <= count_next;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

### hw/rtl/mmm_checker.sv
module mmm_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          mdio_out,
    input  logic                          mdio_drive,
    input  logic                          mdc_active,
    input  logic                          frame_done,
    input  logic [mmm_pkg::DATA_W-1:0]    read_data,
    input  logic                          no_response,
    input  logic                          busy_res,
    input  logic                          rejected
);
    import mmm_pkg::*;

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(frame_done))
        else $error("result beat changed while stalled");

    // the last tick of a frame leaves the block idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_done |-> !busy_res && mdc_active)
        else $error("frame_done without an idle, pulsed tick");

    // a rejected start only happens while a frame runs, with no pulse
    a_reject: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> busy_res && !mdc_active && !frame_done)
        else $error("bad rejected beat");

    // a driven one needs drive enable, and no response reads as zero
    a_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!mdio_out || mdio_drive) && (!no_response || read_data == '0))
        else $error("line or read result inconsistent");

endmodule

bind mdio_management_master_unit mmm_checker u_mmm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .mdio_out    (mdio_out),
    .mdio_drive  (mdio_drive),
    .mdc_active  (mdc_active),
    .frame_done  (frame_done),
    .read_data   (read_data),
    .no_response (no_response),
    .busy_res    (busy_res),
    .rejected    (rejected)
);

### dv/tb_top.sv
module tb_top;

    import mmm_pkg::*;

    // action code 3 is not named in the package: the block treats it as a no-op
    localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

    localparam int ITEM_TARGET  = 1600;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 120;  // long receiver back-pressure stretch
    localparam int SETTLE       = 4;    // result passes through the queue and the result register after accept
    localparam int MAX_REPORTS  = 30;

    // ------------------------------------------------------------------
    // Frame predictor and expected-result store
    // ------------------------------------------------------------------
    class mdio_frame_model;
        logic [PHY_W-1:0]   phy_now;
        logic [PRE_W-1:0]   preamble_now;
        bit                 busy;
        bit                 rd_frame;
        logic [COUNT_W-1:0] ticks_left;
        logic [31:0]        frame_word;
        logic [RX_W-1:0]    rx_bits;
        result_t            pending_results[$];
        int                 errors;
        int                 n_checked;
        int                 n_frames;
        int                 n_silent;
        int                 n_rejected;
        int                 n_cfg;

        function new();
            phy_now      = '0;
            preamble_now = PREAMBLE_RESET;
            busy         = 0;
            rd_frame     = 0;
            ticks_left   = '0;
            frame_word   = '0;
            rx_bits      = '0;
            errors       = 0;
            n_checked    = 0;
            n_frames     = 0;
            n_silent     = 0;
            n_rejected   = 0;
            n_cfg        = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [PRE_W-1:0] val);
            n_cfg++;
            if (idx == CFG_PHY_ADDR)
                phy_now = val[PHY_W-1:0];
            else if (idx == CFG_PREAMBLE)
                preamble_now = val;
        endfunction

        // one MDC period (or a start) through the frame sequencer
        function result_t step_frame(logic [ACTION_W-1:0] act, logic [REG_W-1:0] ra,
                                     logic [DATA_W-1:0] wd, logic mi);
            result_t            r;
            logic [COUNT_W-1:0] lead;
            r = '0;
            if (act == ACT_READ || act == ACT_WRITE)
            begin
                if (busy)
                begin
                    r.rejected = 1'b1;
                end
                else
                begin
                    // preamble saturates at 32 ones
                    lead       = (preamble_now > 6'd32) ? 7'd32 : {1'b0, preamble_now};
                    rd_frame   = (act == ACT_READ);
                    frame_word = {2'b01, (rd_frame ? 2'b10 : 2'b01), phy_now, ra,
                                  (rd_frame ? 2'b00 : 2'b10), (rd_frame ? 16'h0000 : wd)};
                    rx_bits    = '0;
                    ticks_left = lead + 7'd32;
                    busy       = 1;
                end
            end
            else if (act == ACT_TICK && busy)
            begin
                r.mdc_active = 1'b1;
                if (ticks_left > 7'd32)
                begin
                    r.mdio_drive = 1'b1;
                    r.mdio_out   = 1'b1;
                end
                else if (ticks_left >= 7'd1)
                begin
                    // read: line released for turnaround and data
                    if (rd_frame && ticks_left <= 7'd18)
                    begin
                        rx_bits = {rx_bits[RX_W-2:0], mi};
                    end
                    else
                    begin
                        r.mdio_drive = 1'b1;
                        r.mdio_out   = frame_word[ticks_left - 7'd1];
                    end
                end
                if (ticks_left > 0)
                    ticks_left--;
                if (ticks_left == 0)
                begin
                    busy         = 0;
                    r.frame_done = 1'b1;
                    if (rd_frame)
                    begin
                        r.no_response = rx_bits[16];
                        r.read_data   = rx_bits[16] ? 16'h0000 : rx_bits[15:0];
                    end
                end
            end
            r.busy_res = busy;
            return r;
        endfunction

        function void accept_beat(logic [ACTION_W-1:0] act, logic [REG_W-1:0] ra,
                                  logic [DATA_W-1:0] wd, logic mi);
            pending_results.push_back(step_frame(act, ra, wd, mi));
        endfunction

        function void field_check(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_beat(result_t got);
            result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result beat with nothing pending, expected none, got %h",
                             $time, got);
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            field_check("mdio_out",    16'(want.mdio_out),    16'(got.mdio_out));
            field_check("mdio_drive",  16'(want.mdio_drive),  16'(got.mdio_drive));
            field_check("mdc_active",  16'(want.mdc_active),  16'(got.mdc_active));
            field_check("frame_done",  16'(want.frame_done),  16'(got.frame_done));
            field_check("read_data",   want.read_data,        got.read_data);
            field_check("no_response", 16'(want.no_response), 16'(got.no_response));
            field_check("busy_res",    16'(want.busy_res),    16'(got.busy_res));
            field_check("rejected",    16'(want.rejected),    16'(got.rejected));
            if (got.frame_done)  n_frames++;
            if (got.no_response) n_silent++;
            if (got.rejected)    n_rejected++;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [ACTION_W-1:0]    action;
    logic [REG_W-1:0]       reg_addr;
    logic [DATA_W-1:0]      write_data;
    logic                   mdio_in;
    logic                   out_valid;
    logic                   out_ready;
    logic                   mdio_out;
    logic                   mdio_drive;
    logic                   mdc_active;
    logic                   frame_done;
    logic [DATA_W-1:0]      read_data;
    logic                   no_response;
    logic                   busy_res;
    logic                   rejected;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [PRE_W-1:0]       cfg_data;

    mdio_management_master_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .reg_addr    (reg_addr),
        .write_data  (write_data),
        .mdio_in     (mdio_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mdio_out    (mdio_out),
        .mdio_drive  (mdio_drive),
        .mdc_active  (mdc_active),
        .frame_done  (frame_done),
        .read_data   (read_data),
        .no_response (no_response),
        .busy_res    (busy_res),
        .rejected    (rejected),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    mdio_frame_model frames = new();

    int  beats_sent;
    bit  sender_steady;   // phase with no sender gaps
    int  cycle_count;

    // clock: period 4
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog: cycle counter, ends a hung run
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles, %0d results still pending",
                         cycle_count, frames.pending_results.size());
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // result monitor: sampled at the rising edge, before the block updates
    initial
    begin
        result_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got.mdio_out    = mdio_out;
                got.mdio_drive  = mdio_drive;
                got.mdc_active  = mdc_active;
                got.frame_done  = frame_done;
                got.read_data   = read_data;
                got.no_response = no_response;
                got.busy_res    = busy_res;
                got.rejected    = rejected;
                frames.check_beat(got);
            end
        end
    end

    // receiver: random stalls, steady stretches, and two long hold-offs
    // while the sender keeps offering beats so the input side backs up
    initial
    begin
        int hold_idx;
        int steady_left;
        int stall_left;
        int r;
        int hold_at[2];
        hold_at[0]  = 400;
        hold_at[1]  = 1200;
        hold_idx    = 0;
        steady_left = 0;
        stall_left  = 0;
        out_ready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_idx < 2 && frames.n_checked >= hold_at[hold_idx])
            begin
                hold_idx++;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (steady_left > 0)
            begin
                steady_left--;
                out_ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    steady_left = $urandom_range(20, 80);
                else if (r < 22)
                    stall_left = $urandom_range(1, 3);
                else if (r < 25)
                    stall_left = $urandom_range(8, 30);
                out_ready = (stall_left == 0);
            end
        end
    end

    // sender gap: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (sender_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    // offer one beat, hold it until accepted, then maybe idle
    task automatic send_beat(input logic [ACTION_W-1:0] act, input logic [REG_W-1:0] ra,
                             input logic [DATA_W-1:0] wd, input logic mi);
        int gap;
        @(negedge clk);
        in_valid   = 1'b1;
        action     = act;
        reg_addr   = ra;
        write_data = wd;
        mdio_in    = mi;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frames.accept_beat(act, ra, wd, mi);
        beats_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // drop valid right after the last accepted beat so nothing is re-sent
    task automatic release_input();
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [PRE_W-1:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        frames.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // registers only change once every result is back and the pipe is empty
    task automatic reconfigure(input logic [PRE_W-1:0] phy_val, input logic [PRE_W-1:0] pre_val);
        release_input();
        while (frames.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        write_cfg(CFG_PHY_ADDR, phy_val);
        write_cfg(CFG_PREAMBLE, pre_val);
    endtask

    // start, then one tick per MDC period; on a read the PHY reply `resp`
    // (two turnaround bits then data) is fed on the last 18 ticks
    task automatic run_frame(input bit rd, input logic [REG_W-1:0] ra,
                             input logic [DATA_W-1:0] wd, input logic [RX_W-1:0] resp,
                             input int noise_pct, input bit early_noise);
        int   total;
        int   k;
        int   j;
        logic mi;
        total = ((frames.preamble_now > 32) ? 32 : int'(frames.preamble_now)) + 32;
        send_beat(rd ? ACT_READ : ACT_WRITE, ra, wd, 1'($urandom));
        if (early_noise)
        begin
            // start while busy is refused; a no-op leaves the frame alone
            send_beat(rd ? ACT_WRITE : ACT_READ, 5'($urandom), 16'($urandom), 1'b1);
            send_beat(ACT_NOP, 5'($urandom), 16'($urandom), 1'b0);
        end
        for (k = 0; k < total; k++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_beat($urandom_range(0, 1) ? ACT_NOP : 2'($urandom_range(0, 1)),
                          5'($urandom), 16'($urandom), 1'($urandom));
            j  = k - (total - READ_SAMPLED);
            mi = (rd && j >= 0) ? resp[RX_W-1-j] : 1'($urandom);
            send_beat(ACT_TICK, 5'($urandom), 16'($urandom), mi);
        end
    endtask

    function automatic logic [PRE_W-1:0] pick_preamble();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)      return 6'd0;
        else if (r < 55) return 6'($urandom_range(1, 8));
        else if (r < 80) return 6'($urandom_range(9, 31));
        else if (r < 90) return 6'd32;
        else             return 6'($urandom_range(33, 63));
    endfunction

    function automatic logic [PRE_W-1:0] pick_phy();
        int r;
        r = $urandom_range(0, 9);
        // top bit of the data word is not part of the address
        if (r == 0)      return {1'($urandom), 5'd0};
        else if (r == 1) return {1'($urandom), 5'd31};
        else             return 6'($urandom);
    endfunction

    // random PHY reply: mostly a proper turnaround, sometimes nobody home
    function automatic logic [RX_W-1:0] pick_reply();
        logic ta2;
        ta2 = ($urandom_range(0, 3) == 0);
        return {1'($urandom), ta2, 16'($urandom)};
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int n_phase_frames;
        int f;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_TICK;
        reg_addr      = '0;
        write_data    = '0;
        mdio_in       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_PHY_ADDR;
        cfg_data      = '0;
        beats_sent    = 0;
        sender_steady = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // --- directed ---
        // idle: tick and no-op do nothing
        send_beat(ACT_TICK, 5'd31, 16'hffff, 1'b1);
        send_beat(ACT_NOP, 5'd0, 16'h0000, 1'b1);
        // shortest frames, max address, max data; busy start refused
        reconfigure(6'd31, 6'd0);
        run_frame(1'b0, 5'd31, 16'hffff, '0, 0, 1'b1);
        send_beat(ACT_TICK, 5'd0, 16'h0000, 1'b0);
        run_frame(1'b1, 5'd0, 16'h0000, {2'b10, 16'hffff}, 0, 1'b1);
        // preamble over 32 saturates; read with no PHY answering
        reconfigure(6'h20, 6'd63);
        run_frame(1'b1, 5'd31, 16'h0000, {2'b11, 16'h5a5a}, 0, 1'b0);
        run_frame(1'b0, 5'd0, 16'h0000, '0, 0, 1'b0);
        // full preamble, all-zero reply
        reconfigure(6'd21, 6'd32);
        run_frame(1'b1, 5'd10, 16'h1234, {2'b00, 16'h0000}, 0, 1'b0);

        // --- random phases: well-formed frames with random content plus noise ---
        while (beats_sent < ITEM_TARGET)
        begin
            reconfigure(pick_phy(), pick_preamble());
            sender_steady  = ($urandom_range(0, 3) == 0);
            n_phase_frames = $urandom_range(1, 4);
            for (f = 0; f < n_phase_frames && beats_sent < ITEM_TARGET; f++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_beat($urandom_range(0, 1) ? ACT_TICK : ACT_NOP,
                              5'($urandom), 16'($urandom), 1'($urandom));
                run_frame(1'($urandom_range(0, 1)), 5'($urandom), 16'($urandom),
                          pick_reply(), ($urandom_range(0, 9) < 7) ? 4 : 0,
                          ($urandom_range(0, 9) == 0));
            end
        end

        // --- wind down ---
        release_input();
        while (frames.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d beats, checked %0d results, %0d config writes",
                 beats_sent, frames.n_checked, frames.n_cfg);
        $display("Frames completed %0d, reads with no response %0d, starts refused %0d",
                 frames.n_frames, frames.n_silent, frames.n_rejected);
        if (frames.pending_results.size() != 0)
        begin
            frames.errors++;
            $display("%0t: %0d expected results never arrived", $time,
                     frames.pending_results.size());
        end
        if (frames.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
